// ----- rtl/free_address_allocator_defines.svh -----
// Assertion helpers shared by the RTL. Every assertion is clocked on i_clk
// and is switched off while i_rst_n is low.
`ifndef FREE_ADDRESS_ALLOCATOR_DEFINES_SVH
`define FREE_ADDRESS_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/faa_pkg.sv -----
package faa_pkg;

    // Default number of address bits the pool is built for.
    localparam int MAX_BITS_DEF = 8;

    // Fixed field widths of the request, response and configuration.
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_MARK    = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_FIND    = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_USED      = 2'd1,
        ST_NONE_FREE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK_CHK,
        S_MARK_UP,
        S_REL_CHK,
        S_REL_UP,
        S_FIND_CHK,
        S_FIND_WALK,
        S_HOLD
    } t_state;

endpackage

// ----- rtl/faa_req_if.sv -----
interface faa_req_if
    import faa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink (input valid, input mode, input address, output ready);
endinterface

// ----- rtl/faa_rsp_if.sv -----
interface faa_rsp_if
    import faa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   free_address;

    modport source (output valid, output status, output free_address, input ready);
    modport sink (input valid, input status, input free_address, output ready);
endinterface

// ----- rtl/free_address_allocator.sv -----
// Free address allocator: keeps a used bit for each of 2^active_bits addresses and, above
// them, a binary tree of "subtree full" marks, all held in one memory of 2^(MAX_BITS+1)
// one-bit entries (leaves in the lower half, tree nodes in heap order in the upper half).
// A request marks an address used (status 1 if it was already used), releases
// an address (releasing a free address does nothing), or finds the lowest free address
// (status 2 and address zero if the pool is full); mode 3 is answered with status 0 at once.
// Address bits at and above active_bits are ignored. The tree is walked or updated one
// level per cycle through the memory's one read port and one write port; mark, release
// and find each walk every level, but stop right after their first memory read when the
// mark hits a used address, the release hits a free one or the pool is full. Results sit
// in an output register, so a new request is taken while an earlier result waits. After
// reset, and after every write of active_bits (which resizes and empties the pool), a
// clearing pass over all entries, 512 at the default size, runs before the first
// request is taken. Configuration writes saturate active_bits to the range 1 to MAX_BITS.
`include "free_address_allocator_defines.svh"

module free_address_allocator
    import faa_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    faa_req_if.sink          i_req,
    faa_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_active_bits
);

    // Address width of the pool, memory index width and depth.
    localparam int AW    = MAX_BITS;
    localparam int MW    = AW + 1;
    localparam int DEPTH = 2 ** MW;
    // Width of a tree level counter; it must also hold MAX_BITS itself.
    localparam int LVL_W = $clog2(MAX_BITS + 1);
    // Common widths for extending external fields.
    localparam int EW    = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int SW    = (CFG_W > LVL_W) ? CFG_W : LVL_W;

    // Leaves live in the lower half of the memory.
    function automatic logic [MW-1:0] leaf_idx(input logic [AW-1:0] a);
        return {1'b0, a};
    endfunction

    // Tree node at depth d with prefix p sits at heap entry 2^d - 1 + p of the upper half.
    function automatic logic [MW-1:0] node_idx(input logic [LVL_W-1:0] d,
                                               input logic [AW-1:0]    p);
        logic [AW:0] heap;
        heap = ((AW+1)'(1) << d) + {1'b0, p} - (AW+1)'(1);
        return {1'b1, heap[AW-1:0]};
    endfunction

    t_state             r_state, n_state;
    logic [LVL_W-1:0]   r_active_bits, n_active_bits;
    logic [MW-1:0]      r_clr_idx, n_clr_idx;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_p, n_p;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic               r_full, n_full;
    t_status            r_res_status, n_res_status;
    logic [AW-1:0]      r_res_addr, n_res_addr;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [AW-1:0]      r_out_addr, n_out_addr;

    logic               r_mem [DEPTH];
    logic               r_rd_data;
    logic               mem_we;
    logic               mem_wdata;
    logic [MW-1:0]      mem_waddr;
    logic [MW-1:0]      mem_raddr;

    logic               accept;
    logic               slot_free;
    logic               fin;
    t_status            fin_status;
    logic [AW-1:0]      fin_addr;
    logic [AW-1:0]      addr_mask;
    logic [EW-1:0]      in_addr_ext;
    logic [AW-1:0]      in_addr;
    logic [EW-1:0]      out_addr_ext;
    logic [SW-1:0]      cfg_ext;
    logic [LVL_W-1:0]   h_m1;
    logic [LVL_W-1:0]   lvl_inc;
    logic [AW-1:0]      pfx_cur;
    logic               full_now;
    logic [AW-1:0]      p_next;
    logic               in_walk;

    // A request is taken only while idle, and never together with a configuration write.
    assign accept    = i_req.valid && (r_state == S_IDLE) && !i_cfg_we;
    assign slot_free = !r_out_valid || o_rsp.ready;

    assign addr_mask   = ~({AW{1'b1}} << r_active_bits);
    assign in_addr_ext = EW'(i_req.address);
    assign in_addr     = in_addr_ext[AW-1:0] & addr_mask;

    assign h_m1    = r_active_bits - LVL_W'(1);
    assign lvl_inc = r_lvl + LVL_W'(1);
    // Prefix of the current address at the tree level held in r_lvl.
    assign pfx_cur  = r_addr >> (r_active_bits - r_lvl);
    assign full_now = r_full & r_rd_data;
    assign p_next   = (r_p << 1) | AW'(r_rd_data);

    // High in the states that step through the tree levels.
    assign in_walk = (r_state == S_MARK_UP) || (r_state == S_REL_UP) ||
                     (r_state == S_FIND_WALK);

    // Saturate the written pool size to 1 .. MAX_BITS.
    assign cfg_ext = SW'(i_cfg_active_bits);
    always_comb begin
        n_active_bits = r_active_bits;
        if (i_cfg_we) begin
            if (cfg_ext == '0) begin
                n_active_bits = LVL_W'(1);
            end else if (cfg_ext > SW'(MAX_BITS)) begin
                n_active_bits = LVL_W'(MAX_BITS);
            end else begin
                n_active_bits = cfg_ext[LVL_W-1:0];
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        priority if (i_cfg_we) begin
            n_state = S_CLEAR;
        end else if (fin) begin
            n_state = slot_free ? S_IDLE : S_HOLD;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx == '1) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_req.mode)
                            MODE_MARK:    n_state = S_MARK_CHK;
                            MODE_RELEASE: n_state = S_REL_CHK;
                            MODE_FIND:    n_state = S_FIND_CHK;
                            default:      n_state = S_IDLE;
                        endcase
                    end
                end
                S_MARK_CHK:  n_state = S_MARK_UP;
                S_REL_CHK:   n_state = S_REL_UP;
                S_FIND_CHK:  n_state = S_FIND_WALK;
                S_HOLD: begin
                    if (slot_free) begin
                        n_state = S_IDLE;
                    end
                end
                default:     n_state = r_state;
            endcase
        end
    end

    // Memory control, working registers and results.
    always_comb begin
        mem_we     = 1'b0;
        mem_wdata  = 1'b0;
        mem_waddr  = '0;
        mem_raddr  = leaf_idx(r_addr);
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_addr   = '0;
        n_addr     = r_addr;
        n_p        = r_p;
        n_lvl      = r_lvl;
        n_full     = r_full;
        n_clr_idx  = r_clr_idx;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                n_clr_idx = r_clr_idx + MW'(1);
            end
            S_IDLE: begin
                n_addr = in_addr;
                if (accept) begin
                    unique case (i_req.mode)
                        MODE_MARK:    mem_raddr = leaf_idx(in_addr);
                        MODE_RELEASE: mem_raddr = leaf_idx(in_addr);
                        MODE_FIND:    mem_raddr = node_idx('0, '0);
                        default:      fin = 1'b1;
                    endcase
                end
            end
            S_MARK_CHK: begin
                if (r_rd_data) begin
                    fin        = 1'b1;
                    fin_status = ST_USED;
                end else begin
                    // Set the leaf and fetch its sibling for the lowest tree level.
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                    mem_waddr = leaf_idx(r_addr);
                    mem_raddr = leaf_idx(r_addr ^ AW'(1));
                    n_lvl     = h_m1;
                    n_full    = 1'b1;
                end
            end
            S_MARK_UP: begin
                // The node is full when the child on our path and its sibling both are.
                mem_we    = 1'b1;
                mem_wdata = full_now;
                mem_waddr = node_idx(r_lvl, pfx_cur);
                n_full    = full_now;
                if (r_lvl == '0) begin
                    fin = 1'b1;
                end else begin
                    mem_raddr = node_idx(r_lvl, pfx_cur ^ AW'(1));
                    n_lvl     = r_lvl - LVL_W'(1);
                end
            end
            S_REL_CHK: begin
                if (r_rd_data) begin
                    mem_we    = 1'b1;
                    mem_waddr = leaf_idx(r_addr);
                    n_lvl     = '0;
                end else begin
                    fin = 1'b1;
                end
            end
            S_REL_UP: begin
                // Every node on the path loses its full mark.
                mem_we    = 1'b1;
                mem_waddr = node_idx(r_lvl, pfx_cur);
                if (r_lvl == h_m1) begin
                    fin = 1'b1;
                end else begin
                    n_lvl = lvl_inc;
                end
            end
            S_FIND_CHK: begin
                if (r_rd_data) begin
                    fin        = 1'b1;
                    fin_status = ST_NONE_FREE;
                end else begin
                    n_p   = '0;
                    n_lvl = '0;
                    if (h_m1 == '0) begin
                        mem_raddr = leaf_idx('0);
                    end else begin
                        mem_raddr = node_idx(LVL_W'(1), '0);
                    end
                end
            end
            S_FIND_WALK: begin
                // The read data tells whether the left child is full; if so go right.
                if (r_lvl == h_m1) begin
                    fin      = 1'b1;
                    fin_addr = p_next & addr_mask;
                end else begin
                    n_p   = p_next;
                    n_lvl = lvl_inc;
                    if (lvl_inc == h_m1) begin
                        mem_raddr = leaf_idx(p_next << 1);
                    end else begin
                        mem_raddr = node_idx(lvl_inc + LVL_W'(1), p_next << 1);
                    end
                end
            end
            S_HOLD: begin
                mem_raddr = leaf_idx(r_addr);
            end
            default: begin
                mem_raddr = leaf_idx(r_addr);
            end
        endcase
    end

    // Output register; a finished result waits in the hold register while it is full.
    always_comb begin
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        if (fin) begin
            n_res_status = fin_status;
            n_res_addr   = fin_addr;
        end
        priority if (fin && slot_free) begin
            n_out_valid  = 1'b1;
            n_out_status = fin_status;
            n_out_addr   = fin_addr;
        end else if ((r_state == S_HOLD) && slot_free) begin
            n_out_valid  = 1'b1;
            n_out_status = r_res_status;
            n_out_addr   = r_res_addr;
        end else begin
            n_out_valid = r_out_valid && !o_rsp.ready;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE) && !i_cfg_we;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign out_addr_ext       = EW'(r_out_addr);
    assign o_rsp.free_address = out_addr_ext[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_active_bits <= LVL_W'(MAX_BITS);
            r_clr_idx     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_active_bits <= n_active_bits;
            r_clr_idx     <= i_cfg_we ? '0 : n_clr_idx;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_p          <= n_p;
        r_lvl        <= n_lvl;
        r_full       <= n_full;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    // Leaf and tree memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    `FAA_ASSERT_NEXT(a_cfg_blocks_req, i_cfg_we, !i_req.ready, "ready after a config write")
    `FAA_ASSERT_NEXT(a_req_starts_walk, accept && !fin, r_state != S_IDLE, "walk not started")
    `FAA_ASSERT_IMPLY(a_lvl_in_range, in_walk, r_lvl < r_active_bits, "tree level too deep")
    `FAA_ASSERT_IMPLY(a_size_in_range, 1'b1, h_m1 < LVL_W'(MAX_BITS), "pool size out of range")

endmodule

// ----- bench/free_address_allocator_test.sv -----
`timescale 1ns / 100ps

module free_address_allocator_test;
    import faa_pkg::*;

    // The mode code that the allocator answers with status ok and no state change.
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    localparam int POOL_SIZE    = 1 << MAX_BITS_DEF;
    localparam int TREE_SIZE    = POOL_SIZE - 1;
    localparam int MIN_BITS     = 1;
    localparam int LONG_HOLD    = 150;
    localparam int END_SETTLE   = 30;
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
    } request_t;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] free_address;
    } reply_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_active_bits;

    faa_req_if req_bus ();
    faa_rsp_if rsp_bus ();

    free_address_allocator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (req_bus),
        .o_rsp             (rsp_bus),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_active_bits (i_cfg_active_bits)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Requests waiting to be offered, and the replies the allocator owes us, oldest first.
    request_t request_queue[$];
    reply_t   predicted_replies[$];

    // Our own copy of the allocator state: one used bit per address, and the heap-ordered
    // tree of "subtree full" marks (root at slot 0, depth d prefix p at slot 2^d - 1 + p).
    bit used_bits [0:POOL_SIZE-1];
    bit full_bits [0:TREE_SIZE-1];
    int pool_bits = MAX_BITS_DEF;

    // Idling controls. The sender and the receiver each insert random gaps when enabled;
    // receiver_blocked is the long hold-off driven by its own counting process.
    bit sender_gaps_on   = 1'b1;
    bit receiver_gaps_on = 1'b1;
    bit squeeze_armed    = 1'b0;
    bit receiver_blocked = 1'b0;
    int gap_left;
    int stall_left;

    int error_count   = 0;
    int config_writes = 0;
    int mode_count   [0:3] = '{default: 0};
    int status_count [0:3] = '{default: 0};

    function automatic int heap_slot(input int depth, input int unsigned prefix);
        return (1 << depth) - 1 + prefix;
    endfunction

    // Applies one request to the shadow state and returns the reply it must produce.
    function automatic reply_t apply_request(input logic [MODE_W-1:0] mode,
                                             input logic [ADDR_W-1:0] address);
        reply_t      reply;
        int          depth;
        int unsigned leaf;
        int unsigned p;
        bit          full;
        bit          left_full;
        reply.status       = ST_OK;
        reply.free_address = '0;
        // Address bits at and above the active width are simply dropped.
        leaf = address & ((1 << pool_bits) - 1);
        case (mode)
            MODE_MARK: begin
                if (used_bits[leaf]) begin
                    reply.status = ST_USED;
                end else begin
                    used_bits[leaf] = 1'b1;
                    // Refresh the full marks from the leaf's parent up to the root.
                    for (depth = pool_bits - 1; depth >= 0; depth--) begin
                        p = leaf >> (pool_bits - depth);
                        if (depth == pool_bits - 1) begin
                            full = used_bits[2 * p] && used_bits[2 * p + 1];
                        end else begin
                            full = full_bits[heap_slot(depth + 1, 2 * p)] &&
                                   full_bits[heap_slot(depth + 1, 2 * p + 1)];
                        end
                        full_bits[heap_slot(depth, p)] = full;
                    end
                end
            end
            MODE_RELEASE: begin
                // Releasing a free address leaves everything as it is.
                if (used_bits[leaf]) begin
                    used_bits[leaf] = 1'b0;
                    for (depth = 0; depth < pool_bits; depth++) begin
                        full_bits[heap_slot(depth, leaf >> (pool_bits - depth))] = 1'b0;
                    end
                end
            end
            MODE_FIND: begin
                if (full_bits[0]) begin
                    reply.status = ST_NONE_FREE;
                end else begin
                    // Walk down, going right only when the left subtree is full.
                    p = 0;
                    for (depth = 0; depth < pool_bits; depth++) begin
                        if (depth == pool_bits - 1) begin
                            left_full = used_bits[p << 1];
                        end else begin
                            left_full = full_bits[heap_slot(depth + 1, p << 1)];
                        end
                        p = (p << 1) | left_full;
                    end
                    reply.free_address = ADDR_W'(p);
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    // Request driver. A transfer happens at an edge where valid and ready are both high;
    // the reply for it is predicted right there, before the next item is put on the bus.
    always @(posedge i_clk) begin : request_driver
        request_t next_req;
        if (!i_rst_n) begin
            req_bus.valid   <= 1'b0;
            req_bus.mode    <= MODE_MARK;
            req_bus.address <= '0;
            gap_left        <= 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                predicted_replies.push_back(apply_request(req_bus.mode, req_bus.address));
                mode_count[req_bus.mode]++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (gap_left > 0) begin
                    req_bus.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (request_queue.size() != 0) begin
                    next_req        = request_queue.pop_front();
                    req_bus.valid   <= 1'b1;
                    req_bus.mode    <= next_req.mode;
                    req_bus.address <= next_req.address;
                    gap_left        <= sender_gaps_on ? pick_gap() : 0;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor. Every accepted reply is checked against the oldest prediction, and
    // the ready line is stalled at random or held low while the long hold-off runs.
    always @(posedge i_clk) begin : reply_monitor
        reply_t want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                status_count[rsp_bus.status]++;
                if (predicted_replies.size() == 0) begin
                    $display("%0t: reply with no request pending: status %0d, address %0d",
                             $time, rsp_bus.status, rsp_bus.free_address);
                    error_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp_bus.status);
                        error_count++;
                    end
                    if (rsp_bus.free_address !== want.free_address) begin
                        $display("%0t: free_address expected %0d, got %0d",
                                 $time, want.free_address, rsp_bus.free_address);
                        error_count++;
                    end
                end
            end
            if (receiver_blocked) begin
                rsp_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else begin
                rsp_bus.ready <= 1'b1;
                if (receiver_gaps_on && $urandom_range(0, 5) == 0) begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps offering items and the
    // allocator backs up into its input.
    initial begin : receiver_squeeze
        wait (squeeze_armed);
        receiver_blocked <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        receiver_blocked <= 1'b0;
    end

    task automatic push_request(input logic [MODE_W-1:0] mode,
                                input logic [ADDR_W-1:0] address);
        request_t item;
        item.mode    = mode;
        item.address = address;
        request_queue.push_back(item);
    endtask

    // Returns at a falling edge once nothing is waiting, offered or owed.
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || req_bus.valid || predicted_replies.size() != 0);
    endtask

    // Writes active_bits with the allocator idle. The allocator empties its pool on the
    // write, so the shadow state is emptied too, with the same saturation of the value.
    task automatic reconfigure(input logic [CFG_W-1:0] value);
        wait_until_idle();
        @(posedge i_clk);
        i_cfg_we          <= 1'b1;
        i_cfg_active_bits <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (value < MIN_BITS) begin
            pool_bits = MIN_BITS;
        end else if (value > MAX_BITS_DEF) begin
            pool_bits = MAX_BITS_DEF;
        end else begin
            pool_bits = value;
        end
        used_bits = '{default: 1'b0};
        full_bits = '{default: 1'b0};
        config_writes++;
        @(negedge i_clk);
    endtask

    // Random mix: marks outnumber releases so the pool stays busy, with finds throughout
    // and the odd request carrying the unused mode code.
    task automatic queue_random(input int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                push_request(MODE_MARK, ADDR_W'($urandom_range(0, 255)));
            end else if (roll < 70) begin
                push_request(MODE_RELEASE, ADDR_W'($urandom_range(0, 255)));
            end else if (roll < 97) begin
                push_request(MODE_FIND, ADDR_W'($urandom_range(0, 255)));
            end else begin
                push_request(MODE_IGNORED, ADDR_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // Marks every address of the current pool in shuffled order, with junk in the ignored
    // upper bits, then probes the full pool, frees one address and takes it back.
    task automatic queue_fill();
        int unsigned order[];
        int unsigned size;
        int unsigned pick;
        int unsigned held;
        int          i;
        int          j;
        size  = 1 << pool_bits;
        order = new[size];
        for (i = 0; i < size; i++) begin
            order[i] = i;
        end
        for (i = size - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            held     = order[i];
            order[i] = order[j];
            order[j] = held;
        end
        for (i = 0; i < size; i++) begin
            push_request(MODE_MARK, ADDR_W'(order[i] | ($urandom() << pool_bits)));
        end
        pick = $urandom_range(0, size - 1);
        push_request(MODE_FIND, ADDR_W'($urandom_range(0, 255)));
        push_request(MODE_MARK, ADDR_W'(pick));
        push_request(MODE_RELEASE, ADDR_W'(pick));
        push_request(MODE_FIND, ADDR_W'($urandom_range(0, 255)));
        push_request(MODE_MARK, ADDR_W'(pick));
        push_request(MODE_FIND, ADDR_W'($urandom_range(0, 255)));
        push_request(MODE_RELEASE, ADDR_W'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int bits;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_active_bits = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Full 8-bit pool straight out of reset: find on an empty pool, a repeated mark,
        // releases of used and free addresses, both ends of the address range and the
        // unused mode code.
        push_request(MODE_FIND, 8'hFF);
        push_request(MODE_MARK, 8'h00);
        push_request(MODE_MARK, 8'h00);
        push_request(MODE_FIND, 8'h00);
        push_request(MODE_MARK, 8'hFF);
        push_request(MODE_MARK, 8'h01);
        push_request(MODE_FIND, 8'h55);
        push_request(MODE_RELEASE, 8'h00);
        push_request(MODE_RELEASE, 8'h00);
        push_request(MODE_FIND, 8'hAA);
        push_request(MODE_IGNORED, 8'hFF);
        push_request(MODE_MARK, 8'h80);
        push_request(MODE_RELEASE, 8'hFF);
        push_request(MODE_RELEASE, 8'hFF);
        push_request(MODE_FIND, 8'h00);
        queue_random(100);

        // One-bit pool: high address bits dropped, the pool runs full, then frees again.
        reconfigure(CFG_W'(1));
        push_request(MODE_FIND, 8'h00);
        push_request(MODE_MARK, 8'hFE);
        push_request(MODE_MARK, 8'hFF);
        push_request(MODE_FIND, 8'h7F);
        push_request(MODE_MARK, 8'h01);
        push_request(MODE_RELEASE, 8'h02);
        push_request(MODE_FIND, 8'h00);
        queue_random(40);

        // A write of zero saturates to one bit; run it with the receiver always ready.
        reconfigure(CFG_W'(0));
        receiver_gaps_on = 1'b0;
        queue_random(40);

        // A value above the maximum saturates to the full width; fill the whole pool.
        reconfigure(CFG_W'(15));
        receiver_gaps_on = 1'b1;
        queue_fill();
        queue_random(150);

        // Back-to-back requests while the receiver holds off for a long stretch.
        reconfigure(CFG_W'(MAX_BITS_DEF));
        sender_gaps_on = 1'b0;
        queue_random(60);
        squeeze_armed = 1'b1;

        // The sender waits here until every reply is in, then a stretch with no idling
        // on either side.
        wait_until_idle();
        receiver_gaps_on = 1'b0;
        queue_random(100);
        wait_until_idle();
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;

        // Every width in between, each filled to the top and then churned.
        for (bits = 2; bits < MAX_BITS_DEF; bits++) begin
            reconfigure(CFG_W'(bits));
            queue_fill();
            queue_random(60);
        end
        reconfigure(CFG_W'(4));
        queue_random(30);

        // All stimulus is queued; wait for the last reply, then let any stray one show up.
        wait_until_idle();
        repeat (END_SETTLE) @(posedge i_clk);
        if (predicted_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, predicted_replies.size());
            error_count++;
        end

        $display("Covered %0d marks, %0d releases, %0d finds and %0d unused-mode requests.",
                 mode_count[MODE_MARK], mode_count[MODE_RELEASE], mode_count[MODE_FIND],
                 mode_count[MODE_IGNORED]);
        $display("Saw %0d already-used and %0d pool-full replies across %0d width writes.",
                 status_count[ST_USED], status_count[ST_NONE_FREE], config_writes);
        if (error_count == 0) begin
            $display("free_address_allocator_test: clean");
        end else begin
            $display("free_address_allocator_test: errors");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin : run_limit
        #RUN_LIMIT_NS;
        $display("%0t: run limit reached", $time);
        $display("free_address_allocator_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/faa_pkg.sv
rtl/faa_req_if.sv
rtl/faa_rsp_if.sv
rtl/free_address_allocator.sv
bench/free_address_allocator_test.sv
